/* hdl/swrms_pkg.sv */
`timescale 1ns / 1ps

package swrms_pkg;

  // Window length and derived widths
  localparam int WINDOW_LEN = 100;
  localparam int FILL_W     = $clog2(WINDOW_LEN + 1);
  localparam int SLOT_W     = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;

  // Sample, limit and result widths
  localparam int SAMPLE_W = 16;
  localparam int LIMIT_W  = 15;
  localparam int RMS_W    = 16;

  // One square of a 16-bit signed deviation is at most 2^30
  localparam int SQ_W  = 31;
  localparam int SUM_W = $clog2((longint'(WINDOW_LEN) << 30) + 1);

  // Square root: 32-bit radicand, two bits per step
  localparam int ROOT_X_W   = 32;
  localparam int ROOT_STEPS = ROOT_X_W / 2;
  localparam int ROOT_REM_W = RMS_W + 1;

  // Shared subtractor width (covers root trial and divide remainder)
  localparam int SUB_W = (ROOT_REM_W + 2 > FILL_W + 1) ? ROOT_REM_W + 2 : FILL_W + 1;
  localparam int CNT_W = $clog2(SUM_W);

  localparam logic [SAMPLE_W-1:0] ZERO_CODE = SAMPLE_W'(32768);

  // Register map
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam logic [1:0] REG_LOW   = 2'd0;
  localparam logic [1:0] REG_HIGH  = 2'd1;
  localparam logic [1:0] REG_CLAMP = 2'd2;

  localparam logic [LIMIT_W-1:0] LOW_RESET   = LIMIT_W'(6554);
  localparam logic [LIMIT_W-1:0] HIGH_RESET  = LIMIT_W'(9830);
  localparam logic [LIMIT_W-1:0] CLAMP_RESET = LIMIT_W'(16384);

  // Top-level sequencer
  typedef enum logic [2:0] {
    S_IDLE,
    S_SQ_OLD,
    S_SUB_OLD,
    S_SQ_NEW,
    S_ADD_NEW,
    S_START,
    S_MATH,
    S_RESULT
  } seq_state_t;

  // Divide / root unit
  typedef enum logic [1:0] {
    M_IDLE,
    M_DIV,
    M_ROOT,
    M_DONE
  } math_state_t;

  // Handshake between sequencer and divide / root unit
  typedef struct packed {
    logic start;
  } math_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } math_status_t;

endpackage

/* hdl/swrms_math.sv */
`timescale 1ns / 1ps

// Mean square and root: restoring divide of the sum by the fill count, then a
// digit-by-digit square root. Both run on one shared subtractor.
module swrms_math (
  input  logic                            clk,
  input  logic                            rst,
  input  swrms_pkg::math_req_t            req,
  input  logic [swrms_pkg::SUM_W-1:0]     sum,
  input  logic [swrms_pkg::FILL_W-1:0]    fill,
  output swrms_pkg::math_status_t         status,
  output logic [swrms_pkg::RMS_W-1:0]     rms
);

  swrms_pkg::math_state_t state, state_next;

  logic [swrms_pkg::CNT_W-1:0]      cnt;
  logic [swrms_pkg::SUM_W-1:0]      num;
  logic [swrms_pkg::FILL_W-1:0]     div_rem;
  logic [swrms_pkg::FILL_W-1:0]     divisor;
  logic [swrms_pkg::ROOT_X_W-1:0]   x;
  logic [swrms_pkg::ROOT_REM_W-1:0] root_rem;
  logic [swrms_pkg::RMS_W-1:0]      root;

  logic [swrms_pkg::FILL_W:0]       div_sh;
  logic [swrms_pkg::SUB_W-1:0]      root_sh;
  logic [swrms_pkg::SUB_W-1:0]      root_trial;
  logic [swrms_pkg::SUB_W-1:0]      sub_a;
  logic [swrms_pkg::SUB_W-1:0]      sub_b;
  logic [swrms_pkg::SUB_W:0]        sub_diff;
  logic                             sub_ge;

  // Operand forming for both algorithms
  assign div_sh     = {div_rem, num[swrms_pkg::SUM_W-1]};
  assign root_sh    = {root_rem, x[swrms_pkg::ROOT_X_W-1 -: 2]};
  assign root_trial = swrms_pkg::SUB_W'({root, 2'b01});

  // Shared subtract / compare unit
  always_comb begin
    if (state == swrms_pkg::M_ROOT) begin
      sub_a = root_sh;
      sub_b = root_trial;
    end else begin
      sub_a = swrms_pkg::SUB_W'(div_sh);
      sub_b = swrms_pkg::SUB_W'(divisor);
    end
  end

  assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_ge   = ~sub_diff[swrms_pkg::SUB_W];

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swrms_pkg::M_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      swrms_pkg::M_IDLE: begin
        if (req.start) state_next = swrms_pkg::M_DIV;
      end
      swrms_pkg::M_DIV: begin
        if (cnt == '0) state_next = swrms_pkg::M_ROOT;
      end
      swrms_pkg::M_ROOT: begin
        if (cnt == '0) state_next = swrms_pkg::M_DONE;
      end
      swrms_pkg::M_DONE: begin
        state_next = swrms_pkg::M_IDLE;
      end
      default: state_next = swrms_pkg::M_IDLE;
    endcase
  end

  assign status.busy = (state != swrms_pkg::M_IDLE);
  assign status.done = (state == swrms_pkg::M_DONE);
  assign rms         = root;

  // Datapath: one quotient bit or one root bit per cycle
  always_ff @(posedge clk) begin
    case (state)
      swrms_pkg::M_IDLE: begin
        if (req.start) begin
          num     <= sum;
          divisor <= fill;
          div_rem <= '0;
          cnt     <= swrms_pkg::CNT_W'(swrms_pkg::SUM_W - 1);
        end
      end
      swrms_pkg::M_DIV: begin
        div_rem <= sub_ge ? sub_diff[swrms_pkg::FILL_W-1:0] : div_sh[swrms_pkg::FILL_W-1:0];
        num     <= {num[swrms_pkg::SUM_W-2:0], sub_ge};
        if (cnt == '0) begin
          // quotient never exceeds the largest single square
          x        <= swrms_pkg::ROOT_X_W'({num[swrms_pkg::SQ_W-2:0], sub_ge});
          root_rem <= '0;
          root     <= '0;
          cnt      <= swrms_pkg::CNT_W'(swrms_pkg::ROOT_STEPS - 1);
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
      swrms_pkg::M_ROOT: begin
        root_rem <= sub_ge ? sub_diff[swrms_pkg::ROOT_REM_W-1:0]
                           : root_sh[swrms_pkg::ROOT_REM_W-1:0];
        root     <= {root[swrms_pkg::RMS_W-2:0], sub_ge};
        x        <= {x[swrms_pkg::ROOT_X_W-3:0], 2'b00};
        cnt      <= cnt - 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

/* hdl/sliding_window_rms_monitor.sv */
`timescale 1ns / 1ps

// Sliding-window true-RMS monitor. Each input word is a 16-bit offset-binary
// sample (32768 = 0 V, about 3276.8 codes per volt). The last WINDOW_LEN
// deviations sit in an on-chip RAM with a running sum of their squares; the
// mean square (sum / fill count) and its integer root give the RMS in codes,
// checked against the low and high limits and reported clamped plus 32768.
// After a word is accepted the sequencer reads the oldest entry, squares it and
// the new deviation on one multiplier, updates the sum and starts the math: a
// restoring divide over SUM_W quotient bits, a 16-bit square root and a done
// state on one shared subtractor, then the result state. in_ready is high only
// while the sequencer is idle, so a new word is not taken until the last one's
// result has gone to the output register; a finished word waits in the output
// register and a stalled output holds the sequencer in its result state. The user
// must write limits through the APB port only while no word is in flight; the block does not enforce it.
module sliding_window_rms_monitor (
  input  logic                                clk,
  input  logic                                rst,
  // APB configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [swrms_pkg::ADDR_W-1:0]        paddr,
  input  logic [swrms_pkg::DATA_W-1:0]        pwdata,
  output logic [swrms_pkg::DATA_W-1:0]        prdata,
  output logic                                pready,
  // sample channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [swrms_pkg::SAMPLE_W-1:0]      sample_code,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [swrms_pkg::SAMPLE_W-1:0]      level_code,
  output logic                                under_limit,
  output logic                                over_limit,
  output logic                                alarm_start,
  output logic [swrms_pkg::LIMIT_W-1:0]       deviation_code,
  output logic [swrms_pkg::FILL_W-1:0]        window_fill
);

  swrms_pkg::seq_state_t state, state_next;

  logic [swrms_pkg::LIMIT_W-1:0] low_limit;
  logic [swrms_pkg::LIMIT_W-1:0] high_limit;
  logic [swrms_pkg::LIMIT_W-1:0] clamp_limit;

  logic signed [swrms_pkg::SAMPLE_W-1:0] mem [swrms_pkg::WINDOW_LEN];
  logic signed [swrms_pkg::SAMPLE_W-1:0] mem_rdata;

  logic signed [swrms_pkg::SAMPLE_W-1:0] dev;
  logic [swrms_pkg::FILL_W-1:0]          fill_count;
  logic [swrms_pkg::SLOT_W-1:0]          write_slot;
  logic [swrms_pkg::SUM_W-1:0]           square_sum;
  logic [swrms_pkg::SQ_W-1:0]            sq;
  logic                                  out_of_range_seen;
  logic                                  full;

  logic signed [swrms_pkg::SAMPLE_W-1:0]   mul_op;
  logic signed [2*swrms_pkg::SAMPLE_W-1:0] product;

  swrms_pkg::math_req_t          math_req;
  swrms_pkg::math_status_t       math_status;
  logic [swrms_pkg::RMS_W-1:0]   rms;

  logic                          in_acc;
  logic                          load_out;
  logic                          res_under;
  logic                          res_over;
  logic [swrms_pkg::RMS_W:0]     res_gap;
  logic [swrms_pkg::LIMIT_W-1:0] res_dev;
  logic [swrms_pkg::RMS_W-1:0]   res_shown;
  logic [1:0]                    reg_idx;

  // APB register file
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      low_limit   <= swrms_pkg::LOW_RESET;
      high_limit  <= swrms_pkg::HIGH_RESET;
      clamp_limit <= swrms_pkg::CLAMP_RESET;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        swrms_pkg::REG_LOW:   low_limit   <= pwdata[swrms_pkg::LIMIT_W-1:0];
        swrms_pkg::REG_HIGH:  high_limit  <= pwdata[swrms_pkg::LIMIT_W-1:0];
        swrms_pkg::REG_CLAMP: clamp_limit <= pwdata[swrms_pkg::LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      swrms_pkg::REG_LOW:   prdata = swrms_pkg::DATA_W'(low_limit);
      swrms_pkg::REG_HIGH:  prdata = swrms_pkg::DATA_W'(high_limit);
      swrms_pkg::REG_CLAMP: prdata = swrms_pkg::DATA_W'(clamp_limit);
      default:              prdata = '0;
    endcase
  end

  // Handshakes
  assign in_ready = (state == swrms_pkg::S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign load_out = (state == swrms_pkg::S_RESULT) && (!out_valid || out_ready);
  assign full     = (fill_count == swrms_pkg::FILL_W'(swrms_pkg::WINDOW_LEN));

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swrms_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    math_req.start = 1'b0;
    case (state)
      swrms_pkg::S_IDLE: begin
        if (in_acc) state_next = swrms_pkg::S_SQ_OLD;
      end
      swrms_pkg::S_SQ_OLD:  state_next = swrms_pkg::S_SUB_OLD;
      swrms_pkg::S_SUB_OLD: state_next = swrms_pkg::S_SQ_NEW;
      swrms_pkg::S_SQ_NEW:  state_next = swrms_pkg::S_ADD_NEW;
      swrms_pkg::S_ADD_NEW: state_next = swrms_pkg::S_START;
      swrms_pkg::S_START: begin
        math_req.start = 1'b1;
        state_next     = swrms_pkg::S_MATH;
      end
      swrms_pkg::S_MATH: begin
        if (math_status.done) state_next = swrms_pkg::S_RESULT;
      end
      swrms_pkg::S_RESULT: begin
        if (!out_valid || out_ready) state_next = swrms_pkg::S_IDLE;
      end
      default: state_next = swrms_pkg::S_IDLE;
    endcase
  end

  // Window RAM, registered read at the current slot
  always_ff @(posedge clk) begin
    mem_rdata <= mem[write_slot];
    if (state == swrms_pkg::S_SQ_NEW) begin
      mem[write_slot] <= dev;
    end
  end

  // Shared squarer
  assign mul_op  = (state == swrms_pkg::S_SQ_OLD) ? mem_rdata : dev;
  assign product = mul_op * mul_op;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      dev <= $signed(sample_code ^ swrms_pkg::ZERO_CODE);
    end
    if (state == swrms_pkg::S_SQ_OLD || state == swrms_pkg::S_SQ_NEW) begin
      sq <= product[swrms_pkg::SQ_W-1:0];
    end
  end

  // Running sum, fill count and slot
  always_ff @(posedge clk) begin
    if (rst) begin
      square_sum <= '0;
      fill_count <= '0;
      write_slot <= '0;
    end else begin
      case (state)
        swrms_pkg::S_SUB_OLD: begin
          if (full) square_sum <= square_sum - swrms_pkg::SUM_W'(sq);
        end
        swrms_pkg::S_ADD_NEW: begin
          square_sum <= square_sum + swrms_pkg::SUM_W'(sq);
          if (!full) fill_count <= fill_count + 1'b1;
          if (write_slot == swrms_pkg::SLOT_W'(swrms_pkg::WINDOW_LEN - 1)) begin
            write_slot <= '0;
          end else begin
            write_slot <= write_slot + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  swrms_math u_math (
    .clk    (clk),
    .rst    (rst),
    .req    (math_req),
    .sum    (square_sum),
    .fill   (fill_count),
    .status (math_status),
    .rms    (rms)
  );

  // Limit check, distance and clamp
  always_comb begin
    res_under = rms < swrms_pkg::RMS_W'(low_limit);
    res_over  = !res_under && (rms > swrms_pkg::RMS_W'(high_limit));
    if (res_under) begin
      res_gap = (swrms_pkg::RMS_W + 1)'(low_limit) - (swrms_pkg::RMS_W + 1)'(rms);
    end else if (res_over) begin
      res_gap = (swrms_pkg::RMS_W + 1)'(rms) - (swrms_pkg::RMS_W + 1)'(high_limit);
    end else begin
      res_gap = '0;
    end
    if (res_gap[swrms_pkg::RMS_W:swrms_pkg::LIMIT_W] != '0) begin
      res_dev = '1;
    end else begin
      res_dev = res_gap[swrms_pkg::LIMIT_W-1:0];
    end
    res_shown = (rms < swrms_pkg::RMS_W'(clamp_limit)) ? rms : swrms_pkg::RMS_W'(clamp_limit);
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid         <= 1'b0;
      out_of_range_seen <= 1'b0;
    end else if (load_out) begin
      out_valid         <= 1'b1;
      out_of_range_seen <= res_under || res_over;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      level_code     <= swrms_pkg::SAMPLE_W'(res_shown + swrms_pkg::RMS_W'(swrms_pkg::ZERO_CODE));
      under_limit    <= res_under;
      over_limit     <= res_over;
      alarm_start    <= (res_under || res_over) && !out_of_range_seen;
      deviation_code <= res_dev;
      window_fill    <= fill_count;
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= swrms_pkg::FILL_W'(swrms_pkg::WINDOW_LEN))
    else $error("fill count beyond window length");

  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    write_slot <= swrms_pkg::SLOT_W'(swrms_pkg::WINDOW_LEN - 1))
    else $error("write slot beyond window");

  a_one_word: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !in_ready)
    else $error("second word taken while busy");

  a_math_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !math_status.busy)
    else $error("divide/root unit busy while idle");

  a_out_fill: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (window_fill != '0) && level_code[swrms_pkg::SAMPLE_W-1])
    else $error("result with empty window or level below zero code");
`endif

endmodule

/* tb/tb_sliding_window_rms_monitor.sv */
`timescale 1ns / 1ps

module tb_sliding_window_rms_monitor;
  import swrms_pkg::*;

  localparam int CLK_PERIOD  = 8;
  localparam int RESET_LEN   = 12;
  localparam int RANDOM_GOAL = 2000;
  localparam int HOLD_CYCLES = 600;
  localparam int STALL_LIMIT = 6000;
  localparam int TAIL_CYCLES = 120;
  localparam logic [1:0] REG_SPARE = 2'd3;  // unmapped slot, writes ignored
  localparam logic [LIMIT_W-1:0] DEV_SAT = '1;

  // One result word as the block reports it
  typedef struct packed {
    logic [SAMPLE_W-1:0] level;
    logic                under;
    logic                over;
    logic                alarm;
    logic [LIMIT_W-1:0]  deviation;
    logic [FILL_W-1:0]   fill;
  } level_report_t;

  // One sample word to offer, with an optional hand-written expectation
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                has_fixed;
    level_report_t       fixed_result;
  } sample_item_t;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t           kind;
    logic [1:0]          reg_code;
    logic [DATA_W-1:0]   data;
    sample_item_t        item;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [ADDR_W-1:0]    paddr = '0;
  logic [DATA_W-1:0]    pwdata = '0;
  logic [DATA_W-1:0]    prdata;
  logic                 pready;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [SAMPLE_W-1:0]  sample_code = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [SAMPLE_W-1:0]  level_code;
  logic                 under_limit;
  logic                 over_limit;
  logic                 alarm_start;
  logic [LIMIT_W-1:0]   deviation_code;
  logic [FILL_W-1:0]    window_fill;

  sliding_window_rms_monitor dut (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .sample_code    (sample_code),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .level_code     (level_code),
    .under_limit    (under_limit),
    .over_limit     (over_limit),
    .alarm_start    (alarm_start),
    .deviation_code (deviation_code),
    .window_fill    (window_fill)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Shadow of the window: deviations, fill, write slot, sum of squares
  int                  win_dev [WINDOW_LEN];
  int unsigned         win_fill = 0;
  int unsigned         win_slot = 0;
  longint unsigned     win_sum = 0;
  logic                win_out_seen = 1'b0;
  logic [LIMIT_W-1:0]  lim [3] = '{LOW_RESET, HIGH_RESET, CLAMP_RESET};
  logic [1:0]          reg_codes [3] = '{REG_LOW, REG_HIGH, REG_CLAMP};

  sample_item_t        sample_feed [$];
  level_report_t       pending_levels [$];
  stim_row_t           directed_rows [$];

  sample_item_t        held_item;
  level_report_t       predicted;
  int                  gap_left = 0;
  int                  burst_left = 0;
  int                  ready_mode = 0;
  int                  mode_left = 0;
  int                  hold_left = 0;
  int                  hold_requests = 0;
  int                  hold_served = 0;
  int                  stall_cycles = 0;

  int                  mismatch_count = 0;
  int                  accepted_samples = 0;
  int                  results_checked = 0;
  int                  directed_samples = 0;
  int                  random_samples = 0;
  int                  phase_count = 0;
  int                  alarm_hits = 0;
  int                  under_hits = 0;
  int                  over_hits = 0;
  int                  saturated_hits = 0;

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  // Integer square root, built one bit at a time from the top
  function automatic int unsigned floor_root(input longint unsigned x);
    longint unsigned r;
    longint unsigned c;
    r = 0;
    for (int b = 16; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (c * c <= x) r = c;
    end
    return int'(r);
  endfunction

  // Push one sample word through the shadow window and form its result
  task automatic track_window(input logic [SAMPLE_W-1:0] raw, output level_report_t r);
    int              dev;
    longint unsigned mean;
    int unsigned     rms;
    int unsigned     diff;
    int unsigned     shown;
    logic            under;
    logic            over;
    dev = int'(raw) - 32768;
    if (win_fill >= WINDOW_LEN) begin
      win_sum -= longint'(win_dev[win_slot]) * longint'(win_dev[win_slot]);
    end
    win_dev[win_slot] = dev;
    win_sum += longint'(dev) * longint'(dev);
    win_slot = (win_slot + 1) % WINDOW_LEN;
    if (win_fill < WINDOW_LEN) win_fill++;
    mean = win_sum / longint'(win_fill);
    rms = floor_root(mean);
    under = 1'b0;
    over = 1'b0;
    diff = 0;
    if (rms < lim[REG_LOW]) begin
      under = 1'b1;
      diff = lim[REG_LOW] - rms;
    end else if (rms > lim[REG_HIGH]) begin
      over = 1'b1;
      diff = rms - lim[REG_HIGH];
    end
    if (diff > DEV_SAT) diff = DEV_SAT;
    shown = (rms < lim[REG_CLAMP]) ? rms : lim[REG_CLAMP];
    r.level     = SAMPLE_W'(shown + 32768);
    r.under     = under;
    r.over      = over;
    r.alarm     = (under || over) && !win_out_seen;
    r.deviation = LIMIT_W'(diff);
    r.fill      = FILL_W'(win_fill);
    win_out_seen = under || over;
  endtask

  // APB write: setup, then access until pready
  task automatic reg_write(input logic [1:0] code, input logic [DATA_W-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {code, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (code != REG_SPARE) lim[code] = data[LIMIT_W-1:0];
  endtask

  // Read back every limit and compare with the shadow copy
  task automatic check_regs();
    logic [DATA_W-1:0] got;
    foreach (reg_codes[i]) begin
      @(posedge clk);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {reg_codes[i], 2'b00};
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      got = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      if (got != DATA_W'(lim[reg_codes[i]])) begin
        flag_mismatch($sformatf("register %0d reads %0d, written %0d",
                                reg_codes[i], got, lim[reg_codes[i]]));
      end
    end
  endtask

  // Checked between edges so the sender's updates of this edge are settled
  task automatic wait_drained();
    do @(negedge clk);
    while (sample_feed.size() != 0 || in_valid || pending_levels.size() != 0);
  endtask

  task automatic offer_sample(input logic [SAMPLE_W-1:0] s);
    sample_feed.push_back('{sample: s, has_fixed: 1'b0, fixed_result: '0});
  endtask

  // Directed table builders
  task automatic add_sample(input logic [SAMPLE_W-1:0] s);
    directed_rows.push_back('{kind: ROW_SAMPLE, reg_code: REG_LOW, data: '0,
                              item: '{sample: s, has_fixed: 1'b0, fixed_result: '0}});
  endtask

  task automatic add_typed(input logic [SAMPLE_W-1:0] s, input logic [SAMPLE_W-1:0] level,
                           input logic under, input logic over, input logic alarm,
                           input logic [LIMIT_W-1:0] dev, input logic [FILL_W-1:0] fill);
    level_report_t r;
    r = '{level: level, under: under, over: over, alarm: alarm, deviation: dev, fill: fill};
    directed_rows.push_back('{kind: ROW_SAMPLE, reg_code: REG_LOW, data: '0,
                              item: '{sample: s, has_fixed: 1'b1, fixed_result: r}});
  endtask

  task automatic add_write(input logic [1:0] code, input logic [DATA_W-1:0] data);
    directed_rows.push_back('{kind: ROW_WRITE, reg_code: code, data: data, item: '0});
  endtask

  // One stretch of random samples; returns how many were queued
  task automatic queue_segment(output int count);
    int                  kind;
    int                  amp;
    int                  s_int;
    logic [SAMPLE_W-1:0] s;
    kind = $urandom_range(0, 9);
    if (kind <= 1) begin
      // steady level long enough to fill the whole window
      count = $urandom_range(100, 130);
      case ($urandom_range(0, 3))
        0: s = 16'h0000;
        1: s = 16'hFFFF;
        2: s = ZERO_CODE;
        default: s = SAMPLE_W'($urandom);
      endcase
      repeat (count) offer_sample(s);
    end else if (kind <= 6) begin
      // noise in a band around zero volts, rms lands near the limits
      count = $urandom_range(20, 120);
      amp = $urandom_range(0, 28000);
      repeat (count) begin
        s_int = 32768 + int'($urandom_range(0, 2 * amp)) - amp;
        offer_sample(SAMPLE_W'(s_int));
      end
    end else if (kind == 8) begin
      count = $urandom_range(1, 40);
      repeat (count) offer_sample(SAMPLE_W'($urandom));
    end else begin
      // quiet run ending in one full-scale spike
      count = $urandom_range(5, 30);
      repeat (count - 1) offer_sample(ZERO_CODE);
      offer_sample($urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
    end
  endtask

  // Random limit in the full 15-bit range, mostly the documented span
  function automatic logic [LIMIT_W-1:0] pick_limit();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return LIMIT_W'(16384);
      2: return '1;
      3: return LIMIT_W'($urandom_range(0, 32767));
      default: return LIMIT_W'($urandom_range(0, 16384));
    endcase
  endfunction

  // Compare one result word with the oldest expectation
  task automatic check_result();
    level_report_t want;
    if (pending_levels.size() == 0) begin
      flag_mismatch($sformatf("result with nothing expected, level %0d", level_code));
      return;
    end
    want = pending_levels.pop_front();
    results_checked++;
    if (level_code != want.level)
      flag_mismatch($sformatf("result %0d level_code %0d, want %0d",
                              results_checked, level_code, want.level));
    if (under_limit != want.under)
      flag_mismatch($sformatf("result %0d under_limit %0b, want %0b",
                              results_checked, under_limit, want.under));
    if (over_limit != want.over)
      flag_mismatch($sformatf("result %0d over_limit %0b, want %0b",
                              results_checked, over_limit, want.over));
    if (alarm_start != want.alarm)
      flag_mismatch($sformatf("result %0d alarm_start %0b, want %0b",
                              results_checked, alarm_start, want.alarm));
    if (deviation_code != want.deviation)
      flag_mismatch($sformatf("result %0d deviation_code %0d, want %0d",
                              results_checked, deviation_code, want.deviation));
    if (window_fill != want.fill)
      flag_mismatch($sformatf("result %0d window_fill %0d, want %0d",
                              results_checked, window_fill, want.fill));
    if (want.alarm) alarm_hits++;
    if (want.under) under_hits++;
    if (want.over) over_hits++;
    if (want.deviation == DEV_SAT) saturated_hits++;
  endtask

  // Sample sender: bursts of words with random gaps
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
      burst_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        track_window(sample_code, predicted);
        pending_levels.push_back(held_item.has_fixed ? held_item.fixed_result : predicted);
        accepted_samples++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (sample_feed.size() != 0) begin
          held_item = sample_feed.pop_front();
          sample_code <= held_item.sample;
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 9))
              0: gap_left = $urandom_range(81, 200);
              1, 2: gap_left = $urandom_range(6, 80);
              default: gap_left = $urandom_range(0, 5);
            endcase
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result receiver: checks each word, stalls on its own pattern
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_result();
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_served != hold_requests) begin
        // long hold-off so the block backs up into its input
        hold_served = hold_requests;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          ready_mode = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 300);
        end else begin
          mode_left--;
        end
        case (ready_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 7) == 0);
          default: out_ready <= ($urandom_range(0, 39) == 0);
        endcase
      end
    end
  end

  // Watchdog: too long with no word moving on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
        $display("sliding_window_rms_monitor test failed");
        $finish;
      end
    end
  end

  initial begin
    int seg;
    int target;
    int queued;
    logic [LIMIT_W-1:0] lo;
    logic [LIMIT_W-1:0] hi;
    logic [LIMIT_W-1:0] cl;

    // Directed table, reset limits first
    add_typed(ZERO_CODE, 16'd32768, 1'b1, 1'b0, 1'b1, 15'd6554, 7'd1);
    add_typed(ZERO_CODE, 16'd32768, 1'b1, 1'b0, 1'b0, 15'd6554, 7'd2);
    add_sample(16'h0000);
    add_sample(16'hFFFF);
    // zero limits, widest clamp, upper data bits must be dropped
    add_write(REG_LOW, 32'hFFFF_0000);
    add_write(REG_HIGH, 32'h0000_0000);
    add_write(REG_CLAMP, 32'h0001_7FFF);
    add_sample(16'h0000);
    add_sample(16'hFFFF);
    add_sample(16'h7FFF);
    add_sample(16'h8001);
    // crossed limits: low above high, clamp at zero
    add_write(REG_LOW, 32'd16384);
    add_write(REG_HIGH, 32'd100);
    add_write(REG_CLAMP, 32'd0);
    add_sample(16'h0001);
    add_sample(16'hFFFE);
    add_sample(16'h5555);
    add_sample(16'hAAAA);
    add_sample(16'd40000);
    // write to the unmapped slot, then widest in-range band
    add_write(REG_SPARE, 32'd5);
    add_write(REG_LOW, 32'd0);
    add_write(REG_HIGH, 32'd32767);
    add_typed(16'd12345, 16'd32768, 1'b0, 1'b0, 1'b0, 15'd0, 7'd14);
    add_typed(16'd50000, 16'd32768, 1'b0, 1'b0, 1'b0, 15'd0, 7'd15);
    add_typed(ZERO_CODE, 16'd32768, 1'b0, 1'b0, 1'b0, 15'd0, 7'd16);
    add_write(REG_LOW, 32'(LOW_RESET));
    add_write(REG_HIGH, 32'(HIGH_RESET));
    add_write(REG_CLAMP, 32'(CLAMP_RESET));
    add_sample(16'd42598);
    add_sample(16'd22938);
    add_sample(16'd49152);

    repeat (RESET_LEN) @(posedge clk);
    rst <= 1'b0;
    check_regs();

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        wait_drained();
        reg_write(directed_rows[i].reg_code, directed_rows[i].data);
        if (i + 1 >= directed_rows.size() || directed_rows[i + 1].kind != ROW_WRITE)
          check_regs();
      end else begin
        sample_feed.push_back(directed_rows[i].item);
        directed_samples++;
      end
    end
    wait_drained();

    // Random phases, each under its own limit setting
    while (random_samples < RANDOM_GOAL) begin
      case (phase_count % 6)
        0: begin
          lo = LIMIT_W'($urandom_range(0, 16384));
          hi = LIMIT_W'($urandom_range(lo, 16384));
          cl = LIMIT_W'($urandom_range(0, 16384));
        end
        1: begin
          // zero limits and widest clamp: deviation saturates at full scale
          lo = '0;
          hi = '0;
          cl = '1;
        end
        2: begin
          lo = LIMIT_W'(16384);
          hi = LIMIT_W'(16384);
          cl = LIMIT_W'(16384);
        end
        3: begin
          hi = LIMIT_W'($urandom_range(0, 12000));
          lo = LIMIT_W'($urandom_range(hi, 16384));
          cl = pick_limit();
        end
        4: begin
          lo = LOW_RESET;
          hi = HIGH_RESET;
          cl = CLAMP_RESET;
        end
        default: begin
          lo = pick_limit();
          hi = pick_limit();
          cl = pick_limit();
        end
      endcase
      reg_write(REG_LOW, ($urandom & 32'hFFFF_8000) | DATA_W'(lo));
      reg_write(REG_HIGH, ($urandom & 32'hFFFF_8000) | DATA_W'(hi));
      reg_write(REG_CLAMP, ($urandom & 32'hFFFF_8000) | DATA_W'(cl));
      check_regs();

      target = $urandom_range(150, 350);
      queued = 0;
      if (phase_count % 6 == 1) begin
        repeat (110) offer_sample(16'h0000);
        queued = 110;
      end
      while (queued < target) begin
        queue_segment(seg);
        queued += seg;
      end
      if (phase_count % 6 == 2) hold_requests++;
      random_samples += queued;
      phase_count++;
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_levels.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", pending_levels.size()));

    $display("ran %0d directed and %0d random samples over %0d limit settings, %0d results",
             directed_samples, random_samples, phase_count, results_checked);
    $display("seen: %0d under, %0d over, %0d alarm starts, %0d saturated deviations",
             under_hits, over_hits, alarm_hits, saturated_hits);
    if (mismatch_count == 0) begin
      $display("sliding_window_rms_monitor test passed");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("sliding_window_rms_monitor test failed");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/swrms_pkg.sv
hdl/swrms_math.sv
hdl/sliding_window_rms_monitor.sv
tb/tb_sliding_window_rms_monitor.sv
